>>> rtl/ctw_pkg.sv
// ----------------------------------------------------------------------------
// ctw_pkg: shared types and constants for the compact target work block
// widths of the compact word, the 256-bit work datapath and status codes
// ----------------------------------------------------------------------------
package ctw_pkg;

   localparam int WORK_BITS    = 256;
   localparam int WORD_BITS    = 64;
   localparam int COMPACT_BITS = 32;
   localparam int MANT_BITS    = 23;
   localparam int EXP_BITS     = 8;
   localparam int STATUS_BITS  = 2;
   localparam int SHIFT_BITS   = $clog2(WORK_BITS / 8);

   // mantissa holds three bytes, so an exponent of three means no shift
   localparam logic [EXP_BITS-1:0] MANT_BYTES = EXP_BITS'(3);
   // largest exponent whose target still fits when only the low byte is set
   localparam logic [EXP_BITS-1:0] MAX_EXP    = EXP_BITS'(WORK_BITS / 8 + 2);
   // from this exponent on the mantissa is shifted past the top of the target
   localparam logic [EXP_BITS-1:0] EMPTY_EXP  = EXP_BITS'(WORK_BITS / 8 + 3);

   localparam logic [MANT_BITS-1:0] ONE_BYTE_MAX  = MANT_BITS'(24'h0000ff);
   localparam logic [MANT_BITS-1:0] TWO_BYTE_MAX  = MANT_BITS'(24'h00ffff);

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK,
      ST_NEGATIVE,
      ST_OVERFLOW,
      ST_ZERO
   } status_type;

   // decoded target, before the divider is set up
   typedef struct packed {
      logic [WORK_BITS-1:0] target;
      logic                 negative;
      logic                 overflow;
   } decode_type;

   // one divider stage: partial remainder, numerator bits still to shift in
   // with quotient bits collected at the bottom, divisor and status
   typedef struct packed {
      logic [WORK_BITS-1:0] rem;
      logic [WORK_BITS-1:0] nq;
      logic [WORK_BITS-1:0] dvs;
      status_type           status;
   } div_stage_type;

endpackage

>>> rtl/compact_target_work_top.sv
// ----------------------------------------------------------------------------
// compact_target_work_top: proof-of-work value from a compact difficulty word
// decodes the 32-bit compact target and returns 2^256/(target+1) in four
// 64-bit words, with a status code for negative, overflowing or zero targets
// ----------------------------------------------------------------------------
// A transaction is taken whenever start is high; busy is tied low because the
// pipeline accepts a new compact word in every cycle. Each result appears on
// the rsp_ ports for exactly one cycle with rsp_valid high, in the order the
// transactions came in. The pipeline is a decode stage, a setup stage, the
// divider with one restoring step per quotient bit in 256 stages, and the
// output register that also adds the final increment. The receiver cannot
// stall the block, so every result must be captured in the cycle its strobe
// is high. A status of negative, overflow or zero comes with all work words
// zero.
// ----------------------------------------------------------------------------
module compact_target_work_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ctw_pkg::COMPACT_BITS-1:0] req_compact_bits,
   output logic                             rsp_valid,
   output logic [ctw_pkg::WORD_BITS-1:0]    rsp_work_word0,
   output logic [ctw_pkg::WORD_BITS-1:0]    rsp_work_word1,
   output logic [ctw_pkg::WORD_BITS-1:0]    rsp_work_word2,
   output logic [ctw_pkg::WORD_BITS-1:0]    rsp_work_word3,
   output logic [ctw_pkg::STATUS_BITS-1:0]  rsp_status
);
   import ctw_pkg::*;

   // decode stage
   logic [EXP_BITS-1:0]   exp_w;
   logic                  sign_w;
   logic [MANT_BITS-1:0]  mant_raw;
   logic [MANT_BITS-1:0]  mant_adj;
   logic [1:0]            right_bytes;
   logic [SHIFT_BITS-1:0] left_bytes;
   logic                  mant_nonzero;
   decode_type            dec_in;
   decode_type            dec_ff;
   logic                  dec_vld_in;
   logic                  dec_vld_ff;

   // divider stages, index 0 is the setup stage
   logic                  target_zero;
   div_stage_type         setup_in;
   div_stage_type         div_in  [0:WORK_BITS];
   div_stage_type         div_ff  [0:WORK_BITS];
   logic [WORK_BITS:0]    div_vld_in;
   logic [WORK_BITS:0]    div_vld_ff;

   // output register
   logic [WORK_BITS-1:0]  quot_inc;
   logic [WORK_BITS-1:0]  out_work_in;
   logic [WORK_BITS-1:0]  out_work_ff;
   status_type            out_status_in;
   status_type            out_status_ff;
   logic                  out_vld_in;
   logic                  out_vld_ff;

   // no back pressure anywhere in the pipeline
   assign busy = 1'b0;

   // ------------------------------------------------------------------------
   // decode: exponent, sign and mantissa into a 256-bit target
   // ------------------------------------------------------------------------
   always_comb begin
      exp_w       = req_compact_bits[COMPACT_BITS-1 -: EXP_BITS];
      sign_w      = req_compact_bits[MANT_BITS];
      mant_raw    = req_compact_bits[MANT_BITS-1:0];
      right_bytes = 2'(MANT_BYTES[1:0] - exp_w[1:0]);
      left_bytes  = SHIFT_BITS'(exp_w - MANT_BYTES);

      // small exponents drop low mantissa bytes
      if (exp_w <= MANT_BYTES) begin
         mant_adj = mant_raw >> {right_bytes, 3'b000};
      end else begin
         mant_adj = mant_raw;
      end

      if (exp_w <= MANT_BYTES) begin
         dec_in.target = WORK_BITS'(mant_adj);
      end else if (exp_w < EMPTY_EXP) begin
         dec_in.target = WORK_BITS'(mant_adj) << {left_bytes, 3'b000};
      end else begin
         dec_in.target = '0;
      end

      mant_nonzero    = mant_adj != '0;
      dec_in.negative = mant_nonzero && sign_w;
      dec_in.overflow = mant_nonzero &&
                        ((exp_w > MAX_EXP) ||
                         (mant_adj > ONE_BYTE_MAX && exp_w > MAX_EXP - EXP_BITS'(1)) ||
                         (mant_adj > TWO_BYTE_MAX && exp_w > MAX_EXP - EXP_BITS'(2)));
      dec_vld_in = start && !busy;
   end

   // ------------------------------------------------------------------------
   // setup: status, divisor target+1 and numerator ~target
   // ------------------------------------------------------------------------
   always_comb begin
      target_zero  = ~|dec_ff.target;
      setup_in.rem = '0;
      setup_in.nq  = ~dec_ff.target;
      setup_in.dvs = dec_ff.target + WORK_BITS'(1);
      // negative wins over overflow, which wins over zero
      if (dec_ff.negative) begin
         setup_in.status = ST_NEGATIVE;
      end else if (dec_ff.overflow) begin
         setup_in.status = ST_OVERFLOW;
      end else if (target_zero) begin
         setup_in.status = ST_ZERO;
      end else begin
         setup_in.status = ST_OK;
      end
   end

   // ------------------------------------------------------------------------
   // restoring divider: one quotient bit per stage, stages are independent
   // ------------------------------------------------------------------------
   always_comb begin
      logic [WORK_BITS:0]   shifted;
      logic [WORK_BITS+1:0] diff;
      div_in[0] = setup_in;
      for (int k = 0; k < WORK_BITS; k++) begin
         // bring the next numerator bit into the remainder
         shifted = {div_ff[k].rem, div_ff[k].nq[WORK_BITS-1]};
         diff    = {1'b0, shifted} - {2'b00, div_ff[k].dvs};
         div_in[k+1].dvs    = div_ff[k].dvs;
         div_in[k+1].status = div_ff[k].status;
         // no borrow means the divisor fit: subtract and set the quotient bit
         div_in[k+1].rem    = diff[WORK_BITS+1] ? shifted[WORK_BITS-1:0] :
                                                  diff[WORK_BITS-1:0];
         div_in[k+1].nq     = {div_ff[k].nq[WORK_BITS-2:0], !diff[WORK_BITS+1]};
      end
      div_vld_in = {div_vld_ff[WORK_BITS-1:0], dec_vld_ff};
   end

   // ------------------------------------------------------------------------
   // output: quotient + 1, cleared on any error status
   // ------------------------------------------------------------------------
   always_comb begin
      quot_inc      = div_ff[WORK_BITS].nq + WORK_BITS'(1);
      out_status_in = div_ff[WORK_BITS].status;
      out_work_in   = (out_status_in == ST_OK) ? quot_inc : '0;
      out_vld_in    = div_vld_ff[WORK_BITS];
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      dec_ff        <= dec_in;
      div_ff        <= div_in;
      out_work_ff   <= out_work_in;
      out_status_ff <= out_status_in;
   end

   // valid bits travel alongside the payload
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_vld_ff <= 1'b0;
         div_vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         dec_vld_ff <= dec_vld_in;
         div_vld_ff <= div_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_work_word0 = out_work_ff[0*WORD_BITS +: WORD_BITS];
   assign rsp_work_word1 = out_work_ff[1*WORD_BITS +: WORD_BITS];
   assign rsp_work_word2 = out_work_ff[2*WORD_BITS +: WORD_BITS];
   assign rsp_work_word3 = out_work_ff[3*WORD_BITS +: WORD_BITS];
   assign rsp_status     = out_status_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // an accepted transaction shows up in the decode stage next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> dec_vld_ff)
      else $error("accepted transaction lost before decode stage");

   // a result strobe only follows a valid last divider stage
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(div_vld_ff[WORK_BITS]))
      else $error("result strobe without a finished divider stage");

   // error results carry zero work
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_work_word0 == '0 && rsp_work_word1 == '0 &&
         rsp_work_word2 == '0 && rsp_work_word3 == '0)
      else $error("nonzero work with error status");

   // a good target always gives a nonzero work
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |->
         rsp_work_word0 != '0 || rsp_work_word1 != '0 ||
         rsp_work_word2 != '0 || rsp_work_word3 != '0)
      else $error("zero work with ok status");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for compact_target_work_top
// drives compact difficulty words through the command port and checks every
// strobed result against a local model of the decode and 2^256/(target+1)
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import ctw_pkg::*;

   // cycle budget: worst case is every transaction after a long gap plus latency
   localparam int unsigned LIMIT_CYCLES = 1_000_000;
   // extra wait at the end, longer than the block takes to return a result
   localparam int unsigned DRAIN_CYCLES = 300;

   // compact word layout and the exponent limits of the target range
   localparam int unsigned NO_SHIFT_EXP  = 3;
   localparam int unsigned TOP_EXP_1BYTE = 34;
   localparam int unsigned TOP_EXP_2BYTE = 33;
   localparam int unsigned TOP_EXP_3BYTE = 32;
   localparam logic [MANT_BITS-1:0] MANT_1BYTE = 23'h0000ff;
   localparam logic [MANT_BITS-1:0] MANT_2BYTE = 23'h00ffff;
   localparam logic [MANT_BITS-1:0] MANT_3BYTE = 23'h7fffff;

   // one expected result: four work words, word[0] holds bits 63..0
   typedef struct packed {
      logic [3:0][WORD_BITS-1:0] word;
      status_type                status;
   } work_result_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [COMPACT_BITS-1:0]   req_compact_bits;
   logic                      rsp_valid;
   logic [WORD_BITS-1:0]      rsp_work_word0;
   logic [WORD_BITS-1:0]      rsp_work_word1;
   logic [WORD_BITS-1:0]      rsp_work_word2;
   logic [WORD_BITS-1:0]      rsp_work_word3;
   logic [STATUS_BITS-1:0]    rsp_status;

   // work values still owed by the block, oldest first
   work_result_type expected_work[$];
   int unsigned     error_count = 0;
   int unsigned     cycle_count = 0;

   compact_target_work_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_compact_bits (req_compact_bits),
      .rsp_valid        (rsp_valid),
      .rsp_work_word0   (rsp_work_word0),
      .rsp_work_word1   (rsp_work_word1),
      .rsp_work_word2   (rsp_work_word2),
      .rsp_work_word3   (rsp_work_word3),
      .rsp_status       (rsp_status)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // decode the compact word and work out the proof-of-work value
   function automatic work_result_type predict_work(input logic [COMPACT_BITS-1:0] bits);
      logic [EXP_BITS-1:0]  exponent;
      logic [MANT_BITS-1:0] mantissa;
      logic [WORK_BITS-1:0] target;
      logic                 negative;
      logic                 overflow;
      int unsigned          shift;
      work_result_type      res;
      exponent = bits[31:24];
      mantissa = bits[22:0];
      target   = '0;
      // small exponents drop low mantissa bytes, large ones shift up by bytes
      if (exponent <= NO_SHIFT_EXP) begin
         mantissa = mantissa >> (8 * (NO_SHIFT_EXP - exponent));
         target   = WORK_BITS'(mantissa);
      end else begin
         shift = 8 * (exponent - NO_SHIFT_EXP);
         if (shift < WORK_BITS)
            target = WORK_BITS'(mantissa) << shift;
      end
      // sign only counts when something is left of the mantissa
      negative = (mantissa != '0) && bits[23];
      overflow = (mantissa != '0) &&
                 ((exponent > TOP_EXP_1BYTE) ||
                  (mantissa > MANT_1BYTE && exponent > TOP_EXP_2BYTE) ||
                  (mantissa > MANT_2BYTE && exponent > TOP_EXP_3BYTE));
      if (negative)
         res.status = ST_NEGATIVE;
      else if (overflow)
         res.status = ST_OVERFLOW;
      else if (target == '0)
         res.status = ST_ZERO;
      else
         res.status = ST_OK;
      // 2^256/(T+1) without a 257-bit numerator
      if (res.status == ST_OK)
         res.word = (~target) / (target + WORK_BITS'(1)) + WORK_BITS'(1);
      else
         res.word = '0;
      return res;
   endfunction

   // idle cycles ahead of a transaction: mostly none or short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 20);
      else
         return $urandom_range(30, 120);
   endfunction

   // mantissa of one, two or three bytes so all exponent limits get hit
   function automatic logic [MANT_BITS-1:0] random_mantissa();
      logic [MANT_BITS-1:0] value;
      value = MANT_BITS'($urandom);
      case ($urandom_range(0, 2))
         0:       value = value & MANT_1BYTE;
         1:       value = value & MANT_2BYTE;
         default: value = value & MANT_3BYTE;
      endcase
      return value;
   endfunction

   // mostly well-formed difficulty words, then edges and raw noise
   function automatic logic [COMPACT_BITS-1:0] random_compact();
      int unsigned          roll;
      logic [EXP_BITS-1:0]  exponent;
      logic [MANT_BITS-1:0] mantissa;
      logic                 sign;
      roll     = $urandom_range(0, 99);
      mantissa = random_mantissa();
      sign     = 1'b0;
      if (roll < 55) begin
         // realistic positive target
         exponent = EXP_BITS'($urandom_range(NO_SHIFT_EXP, TOP_EXP_3BYTE));
         if (mantissa == '0)
            mantissa = MANT_BITS'(1);
      end else if (roll < 65) begin
         // right-shifted small exponents, sign may be dropped with the bytes
         exponent = EXP_BITS'($urandom_range(0, NO_SHIFT_EXP));
         sign     = 1'($urandom);
      end else if (roll < 80) begin
         // around the top of the 256-bit range
         exponent = EXP_BITS'($urandom_range(30, 37));
         sign     = ($urandom_range(0, 7) == 0);
      end else if (roll < 90) begin
         // zero or tiny mantissa with any exponent
         exponent = EXP_BITS'($urandom);
         mantissa = ($urandom_range(0, 1) == 0) ? '0 : MANT_BITS'($urandom_range(1, 3));
         sign     = 1'($urandom);
      end else begin
         return COMPACT_BITS'($urandom);
      end
      return {exponent, sign, mantissa};
   endfunction

   // present one compact word and wait until the block takes the transaction
   task automatic send_compact(input logic [COMPACT_BITS-1:0] bits,
                               input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start            <= 1'b1;
      req_compact_bits <= bits;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      expected_work.push_back(predict_work(bits));
   endtask

   // field extremes and every status path
   task automatic test_compact_corners();
      send_compact(32'h00000000, pick_gap());   // all zero: zero target
      send_compact(32'hffffffff, pick_gap());   // all ones: negative wins
      send_compact(32'h1d00ffff, pick_gap());   // classic minimum difficulty
      send_compact(32'h03000001, pick_gap());   // target of one
      send_compact(32'h01003456, pick_gap());   // mantissa shifted out
      send_compact(32'h01123456, pick_gap());   // one byte kept
      send_compact(32'h02123456, pick_gap());   // two bytes kept
      send_compact(32'h04800000, pick_gap());   // sign with empty mantissa
      send_compact(32'h01800001, pick_gap());   // sign, mantissa shifted to zero
      send_compact(32'h01810000, pick_gap());   // sign, one bit survives
      send_compact(32'h04923456, pick_gap());   // plain negative
      send_compact(32'h22000001, pick_gap());   // top exponent, one byte fits
      send_compact(32'h23000001, pick_gap());   // exponent past the top
      send_compact(32'h2200ff00, pick_gap());   // two bytes at top exponent
      send_compact(32'h2100ffff, pick_gap());   // two bytes, still fits
      send_compact(32'h21010000, pick_gap());   // three bytes, one too high
      send_compact(32'h207fffff, pick_gap());   // largest target with a three-byte mantissa
      send_compact(32'h23800001, pick_gap());   // negative and overflow
      send_compact(32'h30000001, pick_gap());   // shifted beyond 256 bits
      send_compact(32'hff800000, pick_gap());   // huge exponent, zero mantissa
      send_compact(32'hff7fffff, pick_gap());   // largest positive word
      send_compact(32'h24000000, pick_gap());   // zero mantissa above the top
   endtask

   // full-rate stream, one transaction every cycle
   task automatic test_back_to_back();
      repeat (100)
         send_compact(random_compact(), 0);
   endtask

   // random words in chunks that either stream or idle at random
   task automatic test_random_targets();
      bit streaming;
      repeat (21) begin
         streaming = ($urandom_range(0, 3) == 0);
         repeat (50)
            send_compact(random_compact(), streaming ? 0 : pick_gap());
      end
   endtask

   // every strobed result is matched against the oldest prediction
   always @(posedge clock) begin : check_result
      work_result_type           want;
      logic [3:0][WORD_BITS-1:0] got;
      if (!reset && rsp_valid === 1'b1) begin
         got = {rsp_work_word3, rsp_work_word2, rsp_work_word1, rsp_work_word0};
         if (expected_work.size() == 0) begin
            $display("%0t: result with nothing pending, status %0d", $time, rsp_status);
            error_count++;
         end else begin
            want = expected_work.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (got[i] !== want.word[i]) begin
                  $display("%0t: work_word%0d expected %h actual %h",
                           $time, i, want.word[i], got[i]);
                  error_count++;
               end
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // hard stop in case the block hangs or drops results
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      // every input known from time zero, reset held high at the start
      reset            = 1'b1;
      start            = 1'b0;
      req_compact_bits = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_compact_corners();
      test_back_to_back();
      test_random_targets();

      @(negedge clock);
      start <= 1'b0;
      // let the pipeline drain, then a little extra for stray strobes
      while (expected_work.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/ctw_pkg.sv
rtl/compact_target_work_top.sv
test/tb.sv
